FILE: rtl/bfnn_pkg.sv
// ----------------------------------------------------------------------------
// bfnn_pkg
// Shared types and constants of the brute-force nearest neighbour unit.
// ----------------------------------------------------------------------------
package bfnn_pkg;

  // Default sizing
  localparam int unsigned MaxVectors = 1024;
  localparam int unsigned Dim        = 128;

  // Fixed field widths
  localparam int unsigned ElemW   = 16;
  localparam int unsigned CfgW    = 8;
  localparam int unsigned StatusW = 2;
  localparam int unsigned IndexW  = 10;
  localparam int unsigned DistW   = 39;

  localparam logic [CfgW-1:0] VecLenReset = 8'd128;

  // Command codes
  localparam logic CmdInsert = 1'b0;
  localparam logic CmdQuery  = 1'b1;

  // Status codes
  localparam logic [StatusW-1:0] StInserted = 2'd0;
  localparam logic [StatusW-1:0] StFull     = 2'd1;
  localparam logic [StatusW-1:0] StResult   = 2'd2;
  localparam logic [StatusW-1:0] StEmpty    = 2'd3;

  typedef struct packed {
    logic             cmd;
    logic [ElemW-1:0] element;
    logic             last;
  } req_t;

  typedef struct packed {
    logic [StatusW-1:0] status;
    logic [IndexW-1:0]  index;
    logic [DistW-1:0]   distance;
  } res_t;

  // Travels with each element read of the scan
  typedef struct packed {
    logic vld;
    logic first_elem;
    logic last_elem;
    logic first_slot;
    logic last_slot;
  } scan_tag_t;

endpackage

FILE: rtl/bfnn_ram.sv
// ----------------------------------------------------------------------------
// bfnn_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module bfnn_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 128,
  parameter int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/bfnn_dist.sv
// ----------------------------------------------------------------------------
// bfnn_dist
// Distance datapath: square the element difference, accumulate per slot and
// keep the running minimum with its slot index.
// ----------------------------------------------------------------------------
module bfnn_dist #(
  parameter int unsigned AccW  = 39,
  parameter int unsigned SlotW = 10
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  bfnn_pkg::scan_tag_t        tag_i,    // tag of the read issued this cycle
  input  logic [bfnn_pkg::ElemW-1:0] q_data_i, // read data, arriving in the cycle after issue
  input  logic [bfnn_pkg::ElemW-1:0] v_data_i,
  output logic                       done_o,
  output logic [AccW-1:0]            best_dist_o,
  output logic [SlotW-1:0]           best_idx_o
);
  import bfnn_pkg::*;

  scan_tag_t s1_tag_q, s2_tag_q;
  logic signed [ElemW:0]   diff;
  logic signed [2*ElemW+1:0] dx;
  logic [2*ElemW-1:0]      sq_d, sq_q;
  logic [AccW-1:0]         acc_q, sum;
  logic [AccW-1:0]         best_dist_q;
  logic [SlotW-1:0]        best_idx_q, slot_q, cur_slot;
  logic                    take;
  logic                    done_q;

  // Stage 1: difference and square
  always_comb begin
    diff = $signed({1'b0, q_data_i}) - $signed({1'b0, v_data_i});
    dx   = (2*ElemW+2)'(diff);
    sq_d = (2*ElemW)'(dx * dx);
  end

  // Stage 2: accumulate and compare at the end of each slot
  always_comb begin
    sum      = (s2_tag_q.first_elem ? '0 : acc_q) + AccW'(sq_q);
    cur_slot = s2_tag_q.first_slot ? '0 : slot_q;
    take     = s2_tag_q.first_slot || (sum < best_dist_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_tag_q <= '0;
      s2_tag_q <= '0;
      done_q   <= 1'b0;
    end else begin
      s1_tag_q <= tag_i;
      s2_tag_q <= s1_tag_q;
      done_q   <= s2_tag_q.vld && s2_tag_q.last_elem && s2_tag_q.last_slot;
    end
  end

  always_ff @(posedge clk_i) begin
    sq_q <= sq_d;
    if (s2_tag_q.vld) begin
      acc_q <= sum;
      if (s2_tag_q.last_elem) begin
        slot_q <= cur_slot + 1'b1;
        if (take) begin
          best_dist_q <= sum;
          best_idx_q  <= cur_slot;
        end
      end
    end
  end

  assign done_o      = done_q;
  assign best_dist_o = best_dist_q;
  assign best_idx_o  = best_idx_q;

endmodule

FILE: rtl/brute_force_nearest_neighbor_unit.sv
// ----------------------------------------------------------------------------
// brute_force_nearest_neighbor_unit
// Vector store with exhaustive squared Euclidean nearest neighbour search.
// ----------------------------------------------------------------------------
// Vectors arrive one element per transaction (start high while busy is low).
// Every element that does not end a vector is taken at once, busy staying low. The
// transaction flagged last produces exactly one result, a one-cycle strobe on
// valid_o that the receiver cannot stall; an insert, a dropped insert and a
// query on an empty store report in the cycle after they are taken. After the
// last element of a stored insert or of a query the unit sweeps zeros into
// the unwritten tail of the vector, one element per cycle, and holds busy
// until the sweep ends. A query then scans the first length elements of every
// stored vector through the single read port of the vector memory, one element
// per cycle, before the search result appears; busy stays high throughout. A
// query on an empty store reports at once but still sweeps.
// ----------------------------------------------------------------------------
module brute_force_nearest_neighbor_unit #(
  parameter int unsigned MAX_VECTORS = bfnn_pkg::MaxVectors,
  parameter int unsigned DIM         = bfnn_pkg::Dim
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  // command channel
  input  logic                      start,
  output logic                      busy,
  input  bfnn_pkg::req_t            req_i,
  // configuration: vector_length
  input  logic                      cfg_we_i,
  input  logic [bfnn_pkg::CfgW-1:0] cfg_wdata_i,
  // results
  output logic                      valid_o,
  output bfnn_pkg::res_t            result_o
);
  import bfnn_pkg::*;

  localparam int unsigned AddrW = (MAX_VECTORS * DIM > 1) ? $clog2(MAX_VECTORS * DIM) : 1;
  localparam int unsigned BaseW = $clog2(MAX_VECTORS * DIM + 1);
  localparam int unsigned CntW  = $clog2(MAX_VECTORS + 1);
  localparam int unsigned SlotW = (MAX_VECTORS > 1) ? $clog2(MAX_VECTORS) : 1;
  localparam int unsigned PosW  = $clog2(DIM + 1);
  localparam int unsigned EIdxW = (DIM > 1) ? $clog2(DIM) : 1;
  localparam int unsigned AccW  = 2 * ElemW + $clog2(DIM);
  localparam int unsigned CmpW  = (PosW > CfgW) ? PosW : CfgW;
  localparam int unsigned SatW  = (AccW > DistW) ? AccW : DistW;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_ZFILL = 5'b00010, // zero the tail of the inserted vector
    S_QFILL = 5'b00100, // zero the tail of the query buffer
    S_SCAN  = 5'b01000,
    S_DRAIN = 5'b10000
  } state_e;

  state_e            state_q, state_d;
  logic [CfgW-1:0]   vlen_q;
  logic [PosW-1:0]   pos_q, pos_d, pos_n;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic [BaseW-1:0]  wbase_q, wbase_d;
  logic [BaseW-1:0]  fbase_q, fbase_d;
  logic [PosW-1:0]   fptr_q, fptr_d;
  logic [PosW-1:0]   slen_q, slen_d;
  logic [SlotW-1:0]  slot_q, slot_d;
  logic [EIdxW-1:0]  elem_q, elem_d;
  logic [BaseW-1:0]  sbase_q, sbase_d;
  logic              valid_q, valid_d;
  res_t              result_q, result_d;

  logic [CmpW-1:0]   vlen_ext;
  logic [PosW-1:0]   len;
  logic              accept, full, wr_ok, fill_last, last_elem, last_slot;

  logic              vs_we, qb_we;
  logic [AddrW-1:0]  vs_waddr, vs_raddr;
  logic [EIdxW-1:0]  qb_waddr;
  logic [ElemW-1:0]  vs_wdata, qb_wdata, vs_rdata, qb_rdata;

  scan_tag_t         tag;
  logic              dist_done;
  logic [AccW-1:0]   best_dist;
  logic [SlotW-1:0]  best_idx;
  logic [SatW-1:0]   best_wide;
  logic [DistW-1:0]  best_sat;

  // Effective length: zero acts as one, anything above DIM as DIM
  always_comb begin
    vlen_ext = CmpW'(vlen_q);
    if (vlen_ext == '0) begin
      len = PosW'(1);
    end else if (vlen_ext > CmpW'(DIM)) begin
      len = PosW'(DIM);
    end else begin
      len = PosW'(vlen_ext);
    end
  end

  assign busy      = (state_q != S_IDLE);
  assign accept    = start && (state_q == S_IDLE);
  assign full      = (cnt_q == CntW'(MAX_VECTORS));
  assign wr_ok     = (pos_q < len);
  assign pos_n     = wr_ok ? pos_q + 1'b1 : pos_q;
  assign fill_last = (fptr_q == PosW'(DIM - 1));
  assign last_elem = (PosW'(elem_q) + 1'b1 == slen_q);
  assign last_slot = (CntW'(slot_q) + 1'b1 == cnt_q);

  // Scan read addresses: slot base plus element offset
  assign vs_raddr = AddrW'(sbase_q + BaseW'(elem_q));

  always_comb begin
    tag            = '0;
    tag.vld        = (state_q == S_SCAN);
    tag.first_elem = (elem_q == '0);
    tag.last_elem  = last_elem;
    tag.first_slot = (slot_q == '0);
    tag.last_slot  = last_slot;
  end

  // Saturate the winning distance to the result field
  always_comb begin
    best_wide = SatW'(best_dist);
    if (best_wide > SatW'({DistW{1'b1}})) begin
      best_sat = '1;
    end else begin
      best_sat = DistW'(best_wide);
    end
  end

  always_comb begin
    state_d  = state_q;
    pos_d    = pos_q;
    cnt_d    = cnt_q;
    wbase_d  = wbase_q;
    fbase_d  = fbase_q;
    fptr_d   = fptr_q;
    slen_d   = slen_q;
    slot_d   = slot_q;
    elem_d   = elem_q;
    sbase_d  = sbase_q;
    valid_d  = 1'b0;
    result_d = result_q;

    vs_we    = 1'b0;
    vs_waddr = AddrW'(wbase_q + BaseW'(pos_q));
    vs_wdata = req_i.element;
    qb_we    = 1'b0;
    qb_waddr = pos_q[EIdxW-1:0];
    qb_wdata = req_i.element;

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          // Each element goes where its own command sends it
          if (wr_ok) begin
            if (req_i.cmd == CmdQuery) begin
              qb_we = 1'b1;
            end else if (!full) begin
              vs_we = 1'b1;
            end
          end
          if (!req_i.last) begin
            pos_d = pos_n;
          end else begin
            pos_d           = '0;
            fptr_d          = pos_n;
            valid_d         = 1'b1;
            result_d        = '0;
            if (req_i.cmd == CmdInsert) begin
              if (full) begin
                result_d.status = StFull;
              end else begin
                result_d.status = StInserted;
                result_d.index  = IndexW'(cnt_q);
                cnt_d           = cnt_q + 1'b1;
                wbase_d         = wbase_q + BaseW'(DIM);
                fbase_d         = wbase_q;
                if (pos_n != PosW'(DIM)) begin
                  state_d = S_ZFILL;
                end
              end
            end else begin
              slen_d  = len;
              slot_d  = '0;
              elem_d  = '0;
              sbase_d = '0;
              if (cnt_q == '0) begin
                result_d.status = StEmpty;
                if (pos_n != PosW'(DIM)) begin
                  state_d = S_QFILL;
                end
              end else begin
                valid_d = 1'b0;
                state_d = (pos_n != PosW'(DIM)) ? S_QFILL : S_SCAN;
              end
            end
          end
        end
      end

      S_ZFILL: begin
        vs_we    = 1'b1;
        vs_waddr = AddrW'(fbase_q + BaseW'(fptr_q));
        vs_wdata = '0;
        fptr_d   = fptr_q + 1'b1;
        if (fill_last) begin
          state_d = S_IDLE;
        end
      end

      S_QFILL: begin
        qb_we    = 1'b1;
        qb_waddr = fptr_q[EIdxW-1:0];
        qb_wdata = '0;
        fptr_d   = fptr_q + 1'b1;
        if (fill_last) begin
          state_d = (cnt_q == '0) ? S_IDLE : S_SCAN;
        end
      end

      S_SCAN: begin
        // Advance one element per cycle, slot by slot
        if (last_elem) begin
          elem_d  = '0;
          slot_d  = slot_q + 1'b1;
          sbase_d = sbase_q + BaseW'(DIM);
          if (last_slot) begin
            state_d = S_DRAIN;
          end
        end else begin
          elem_d = elem_q + 1'b1;
        end
      end

      S_DRAIN: begin
        // Wait for the last compare to leave the datapath
        if (dist_done) begin
          valid_d           = 1'b1;
          result_d.status   = StResult;
          result_d.index    = IndexW'(best_idx);
          result_d.distance = best_sat;
          state_d           = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      vlen_q  <= VecLenReset;
      pos_q   <= '0;
      cnt_q   <= '0;
      wbase_q <= '0;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        vlen_q <= cfg_wdata_i;
      end
      pos_q   <= pos_d;
      cnt_q   <= cnt_d;
      wbase_q <= wbase_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    fbase_q  <= fbase_d;
    fptr_q   <= fptr_d;
    slen_q   <= slen_d;
    slot_q   <= slot_d;
    elem_q   <= elem_d;
    sbase_q  <= sbase_d;
    result_q <= result_d;
  end

  bfnn_ram #(
    .Width (ElemW),
    .Depth (MAX_VECTORS * DIM),
    .AddrW (AddrW)
  ) u_vec_store (
    .clk_i   (clk_i),
    .we_i    (vs_we),
    .waddr_i (vs_waddr),
    .wdata_i (vs_wdata),
    .raddr_i (vs_raddr),
    .rdata_o (vs_rdata)
  );

  bfnn_ram #(
    .Width (ElemW),
    .Depth (DIM),
    .AddrW (EIdxW)
  ) u_query_buf (
    .clk_i   (clk_i),
    .we_i    (qb_we),
    .waddr_i (qb_waddr),
    .wdata_i (qb_wdata),
    .raddr_i (elem_q),
    .rdata_o (qb_rdata)
  );

  bfnn_dist #(
    .AccW  (AccW),
    .SlotW (SlotW)
  ) u_dist (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .tag_i       (tag),
    .q_data_i    (qb_rdata),
    .v_data_i    (vs_rdata),
    .done_o      (dist_done),
    .best_dist_o (best_dist),
    .best_idx_o  (best_idx)
  );

  assign valid_o  = valid_q;
  assign result_o = result_q;

endmodule

FILE: tb/bfnn_checker.sv
// ----------------------------------------------------------------------------
// bfnn_checker
// Watches the element and result channels of the nearest neighbour unit,
// keeps its own copy of the vector store and compares every result.
// ----------------------------------------------------------------------------
module bfnn_checker
  import bfnn_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic            busy_i,
  input  req_t            req_i,
  input  logic            cfg_we_i,
  input  logic [CfgW-1:0] cfg_wdata_i,
  input  logic            valid_i,
  input  res_t            result_i,
  output int unsigned     fail_count_o,
  output int unsigned     pending_o,
  output int unsigned     elements_o,
  output int unsigned     searches_o,
  output int unsigned     drops_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint unsigned DistCap = (64'd1 << DistW) - 64'd1;

  logic [ElemW-1:0] store_mem [MaxVectors][Dim];
  logic [ElemW-1:0] probe_buf [Dim];
  int unsigned      slots_used;
  int unsigned      fill_pos;
  logic [CfgW-1:0]  len_reg;
  res_t             due_results [$];

  initial begin
    fail_count_o = 0;
    pending_o    = 0;
    elements_o   = 0;
    searches_o   = 0;
    drops_o      = 0;
  end

  function automatic void flag(string msg);
    fail_count_o++;
    if (fail_count_o <= 10) $display("%0t checker: %s", $time, msg);
  endfunction

  // Take one element into the shadow state; queue the outcome on a last.
  function automatic void absorb_element(req_t el);
    int unsigned     span;
    int unsigned     at;
    int unsigned     k;
    int unsigned     slot;
    int unsigned     best_slot;
    longint unsigned sum;
    longint unsigned best_sum;
    longint          diff;
    bit              full;
    res_t            outcome;
    span = (len_reg == '0) ? 1 : ((len_reg > Dim) ? Dim : len_reg);
    full = (slots_used >= MaxVectors);
    at   = fill_pos;
    if (at < span) begin
      if (el.cmd == CmdQuery) probe_buf[at] = el.element;
      else if (!full) store_mem[slots_used][at] = el.element;
      at++;
    end
    if (!el.last) begin
      fill_pos = at;
      return;
    end
    fill_pos = 0;
    outcome  = '0;
    if (el.cmd == CmdInsert) begin
      if (full) begin
        outcome.status = StFull;
        drops_o++;
      end else begin
        for (k = at; k < Dim; k++) store_mem[slots_used][k] = '0;
        outcome.status = StInserted;
        outcome.index  = IndexW'(slots_used);
        slots_used++;
      end
    end else begin
      for (k = at; k < Dim; k++) probe_buf[k] = '0;
      if (slots_used == 0) begin
        outcome.status = StEmpty;
      end else begin
        best_slot = 0;
        best_sum  = 0;
        for (slot = 0; slot < slots_used; slot++) begin
          sum = 0;
          for (k = 0; k < span; k++) begin
            diff = longint'(probe_buf[k]) - longint'(store_mem[slot][k]);
            sum += longint'(diff * diff);
          end
          // strict compare keeps the lowest slot on a tie
          if (slot == 0 || sum < best_sum) begin
            best_sum  = sum;
            best_slot = slot;
          end
        end
        outcome.status   = StResult;
        outcome.index    = IndexW'(best_slot);
        outcome.distance = DistW'((best_sum > DistCap) ? DistCap : best_sum);
        searches_o++;
      end
    end
    due_results = {due_results, outcome};
  endfunction

  always @(posedge clk_i) begin : watch
    res_t want;
    if (!rst_ni) begin
      due_results.delete();
      slots_used = 0;
      fill_pos   = 0;
      len_reg    = VecLenReset;
    end else begin
      // results first: one raised at this edge belongs to an earlier element
      if (valid_i) begin
        if (due_results.size() == 0) begin
          flag($sformatf("result with nothing due: status %0d index %0d distance %0d",
                         result_i.status, result_i.index, result_i.distance));
        end else begin
          want = due_results.pop_front();
          if (result_i.status !== want.status || result_i.index !== want.index ||
              result_i.distance !== want.distance) begin
            flag($sformatf({"result mismatch: status %0d/%0d index %0d/%0d ",
                            "distance %0d/%0d (expected/actual)"},
                           want.status, result_i.status, want.index, result_i.index,
                           want.distance, result_i.distance));
          end
        end
      end
      if (start_i && !busy_i) begin
        elements_o++;
        absorb_element(req_i);
      end
      // an element taken at the same edge still used the old length
      if (cfg_we_i) len_reg = cfg_wdata_i;
    end
    pending_o = due_results.size();
  end

endmodule

FILE: tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the brute-force nearest neighbour unit. Directed
// vectors cover the empty store, ties, short and over-long vectors,
// mixed commands and out-of-range lengths; random vectors follow under
// several lengths and sender gap rates, then the store is filled to capacity.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import bfnn_pkg::*;

  // Longest silent stretch: a full-length scan of a full store plus the
  // zero sweep, taken several times over.
  localparam int unsigned StallLimit = 4 * (MaxVectors * Dim + 4 * Dim + 64);
  localparam int unsigned KeepN      = 16;

  typedef enum int unsigned {
    FillRandom,
    FillZero,
    FillOnes,
    FillNearCopy
  } fill_e;

  logic            clk_i       = 1'b0;
  logic            rst_ni      = 1'b0;
  logic            start       = 1'b0;
  logic            busy;
  req_t            req_i       = '0;
  logic            cfg_we_i    = 1'b0;
  logic [CfgW-1:0] cfg_wdata_i = '0;
  logic            valid_o;
  res_t            result_o;

  int unsigned fail_count;
  int unsigned pending;
  int unsigned elements;
  int unsigned searches;
  int unsigned drops;

  int unsigned idle_pct;
  int unsigned span_now;
  int unsigned slots_sent;
  int unsigned stall_cycles;

  // recent insert vectors, kept to aim queries close to stored data
  logic [ElemW-1:0] kept_vec [KeepN][Dim];
  int unsigned      kept_n;
  int unsigned      kept_wr;

  brute_force_nearest_neighbor_unit uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .req_i       (req_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .valid_o     (valid_o),
    .result_o    (result_o)
  );

  bfnn_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start),
    .busy_i       (busy),
    .req_i        (req_i),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .valid_i      (valid_o),
    .result_i     (result_o),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .elements_o   (elements),
    .searches_o   (searches),
    .drops_o      (drops)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // Drive one element and hold it until the unit takes the transaction.
  // Gaps are drawn per cycle, so they land on every phase of the work.
  task automatic send_elem(logic cmd, logic [ElemW-1:0] val, logic lst);
    req_t el;
    el.cmd     = cmd;
    el.element = val;
    el.last    = lst;
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    start <= 1'b1;
    req_i <= el;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    // a committed insert takes a slot while the store has room
    if (lst && cmd == CmdInsert && slots_sent < MaxVectors) slots_sent++;
  endtask

  // Drop start and hold off until every due result is in and the zero
  // sweep behind the last vector has had time to finish.
  task automatic settle();
    start <= 1'b0;
    @(negedge clk_i);
    while (pending != 0) @(negedge clk_i);
    repeat (Dim + 4) @(posedge clk_i);
  endtask

  task automatic write_len(logic [CfgW-1:0] val);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    span_now = (val == '0) ? 1 : ((val > Dim) ? Dim : val);
  endtask

  // Send a whole vector. A mixed vector scatters random commands over all
  // elements but the last, which always queries, so that no store slot is
  // ever left with a position that was never written.
  task automatic send_vector(logic cmd, int unsigned n_items, fill_e mode, bit mixed);
    logic [ElemW-1:0] vals [Dim+4];
    int unsigned      pick;
    int unsigned      k;
    logic             el_cmd;
    if (mode == FillNearCopy && kept_n == 0) mode = FillRandom;
    pick = (kept_n > 0) ? $urandom_range(kept_n - 1) : 0;
    for (k = 0; k < n_items; k++) begin
      case (mode)
        FillZero: vals[k] = '0;
        FillOnes: vals[k] = '1;
        FillNearCopy: begin
          vals[k] = (k < Dim) ? kept_vec[pick][k] : ElemW'($urandom);
          // nudge the low bits now and then; an exact copy makes a tie
          if ($urandom_range(3) == 0) vals[k] = vals[k] ^ ElemW'($urandom_range(1, 7));
        end
        default: vals[k] = ElemW'($urandom);
      endcase
    end
    for (k = 0; k < n_items; k++) begin
      el_cmd = (mixed && k + 1 < n_items) ? 1'($urandom_range(1)) : cmd;
      send_elem(el_cmd, vals[k], k + 1 == n_items);
    end
    if (cmd == CmdInsert && !mixed) begin
      for (k = 0; k < Dim; k++) begin
        kept_vec[kept_wr][k] = (k < n_items && k < span_now) ? vals[k] : '0;
      end
      kept_wr = (kept_wr + 1) % KeepN;
      if (kept_n < KeepN) kept_n++;
    end
  endtask

  // Mostly well-formed vectors; the rest short, over-long or mixed.
  // Ignored elements past the length do not count towards the quota.
  task automatic run_random(int unsigned quota);
    int unsigned spent;
    int unsigned n;
    logic        cmd;
    bit          mixed;
    fill_e       mode;
    spent = 0;
    while (spent < quota) begin
      cmd = ($urandom_range(99) < 40) ? CmdQuery : CmdInsert;
      case ($urandom_range(9))
        0:       n = $urandom_range(1, span_now);
        1:       n = span_now + $urandom_range(1, 4);
        default: n = span_now;
      endcase
      mode  = fill_e'($urandom_range(3));
      mixed = (cmd == CmdQuery) && ($urandom_range(99) < 10);
      send_vector(cmd, n, mode, mixed);
      spent += (n < span_now) ? n : span_now;
      if ($urandom_range(99) < 3) settle();
    end
  endtask

  initial begin : stimulus
    int unsigned ph;
    idle_pct   = 31;
    span_now   = Dim;
    slots_sent = 0;
    kept_n     = 0;
    kept_wr    = 0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // ---- directed part, length at its reset value of 128 ----
    // Query an empty store; the single element also zero-fills the buffer.
    send_elem(CmdQuery, 16'hFFFF, 1'b1);
    // Store two short vectors; the unsent tail goes in as zeros.
    send_elem(CmdInsert, 16'hFFFF, 1'b1);
    send_elem(CmdInsert, 16'h0000, 1'b0);
    send_elem(CmdInsert, 16'h0000, 1'b1);
    send_elem(CmdQuery, 16'hFFFF, 1'b1);
    // Duplicate slot 1 so that the next query ties; the lower slot must win.
    send_elem(CmdInsert, 16'h0000, 1'b1);
    send_elem(CmdQuery, 16'h0001, 1'b1);
    // Mixed commands: the last transaction decides the operation.
    send_elem(CmdInsert, 16'h1234, 1'b0);
    send_elem(CmdQuery, 16'h0000, 1'b1);
    send_elem(CmdQuery, 16'h00FF, 1'b0);
    send_elem(CmdInsert, 16'h8000, 1'b1);
    // Length zero acts as one; the extra elements are dropped.
    settle();
    write_len(8'd0);
    send_elem(CmdInsert, 16'h0005, 1'b0);
    send_elem(CmdInsert, 16'h0007, 1'b0);
    send_elem(CmdInsert, 16'h0009, 1'b1);
    send_elem(CmdQuery, 16'h0006, 1'b1);
    // Lengths beyond the dimension clamp to it.
    settle();
    write_len(8'hFF);
    send_elem(CmdQuery, 16'h1234, 1'b0);
    send_elem(CmdQuery, 16'h8000, 1'b1);
    // Shorten the length in the middle of a vector.
    settle();
    write_len(8'd2);
    send_elem(CmdQuery, 16'h0005, 1'b0);
    settle();
    write_len(8'd1);
    send_elem(CmdQuery, 16'h0009, 1'b1);

    // ---- random part: two lengths per sender gap rate ----
    for (ph = 0; ph < 6; ph++) begin
      idle_pct = (ph < 2) ? 31 : ((ph < 4) ? 58 : 0);
      settle();
      case (ph)
        0:       write_len(8'd128);
        1:       write_len(8'd1);
        2:       write_len(8'd8);
        3:       write_len(8'd0);
        4:       write_len(8'hFF);
        default: write_len(CfgW'($urandom_range(2, 40)));
      endcase
      run_random(16);
    end

    // ---- fill the store with one-element vectors, then push past full ----
    settle();
    write_len(8'd1);
    while (slots_sent < MaxVectors) send_vector(CmdInsert, 1, FillRandom, 1'b0);
    send_vector(CmdInsert, 1, FillRandom, 1'b0);
    settle();
    write_len(8'd3);
    send_vector(CmdInsert, 3, FillRandom, 1'b0);
    repeat (4) send_vector(CmdQuery, 3, FillRandom, 1'b0);
    settle();
    write_len(8'd1);
    repeat (8) send_vector(CmdQuery, 1, FillNearCopy, 1'b0);
    // one full-length scan over the full store with an all-ones query: far
    // from the zero-tailed store, so the top distance bits get exercised
    settle();
    write_len(8'd128);
    send_vector(CmdQuery, Dim, FillOnes, 1'b0);

    // drain, then leave room for anything stray
    settle();
    $display("run covered %0d element transactions, %0d vectors stored, %0d searches,",
             elements, slots_sent, searches);
    $display("  %0d full-store drops, lengths 0/1/3/8/128/255 and random, gaps 31/58/0 pct",
             drops);
    if (fail_count == 0 && pending == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

  // Count cycles that move no transaction; give up past the limit.
  always @(posedge clk_i) begin : watchdog
    if (!rst_ni || (start && !busy) || valid_o) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= StallLimit) begin
      $display("watchdog: no transaction for %0d cycles", stall_cycles);
      $display("tb_top NOT OK");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

endmodule

FILE: brute_force_nearest_neighbor_unit.f
rtl/bfnn_pkg.sv
rtl/bfnn_ram.sv
rtl/bfnn_dist.sv
rtl/brute_force_nearest_neighbor_unit.sv
tb/bfnn_checker.sv
tb/tb_top.sv
